// ===== rtl/atomic_site_update_vacancy_set_defines.svh =====
// ----------------------------------------------------------------------------
// atomic site update defines
// assertion macros shared by the block's modules
// ----------------------------------------------------------------------------
`ifndef ATOMIC_SITE_UPDATE_VACANCY_SET_DEFINES_SVH
`define ATOMIC_SITE_UPDATE_VACANCY_SET_DEFINES_SVH

// same-cycle implication
`define ASVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/asvs_pkg.sv =====
// ----------------------------------------------------------------------------
// asvs_pkg
// shared types and constants of the site update block
// ----------------------------------------------------------------------------
package asvs_pkg;

    localparam int SITE_W     = 12;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_VACANT_CODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VACANCY_LIMIT = 8'd1;

    localparam logic [CODE_W-1:0]  VACANT_CODE_RST   = 8'd255;
    localparam logic [COUNT_W-1:0] VACANCY_LIMIT_RST = 9'd256;

    typedef struct packed {
        logic push;
        logic clr_step;
        logic start;
        logic set_fail;
        logic chk_rd;
        logic chk_cmp;
        logic spw;
        logic rm_rd;
        logic rm_wr;
        logic rm_mv;
        logic ad_rd;
        logic ad_wr;
        logic idx_clr;
        logic idx_inc;
        logic load_out;
        logic end_batch;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic bad;
        logic mismatch;
        logic count_ok;
        logic idx_last;
        logic rm_q;
        logic ad_q;
        logic rm_move;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/asvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// asvs_ctrl
// sequencer for batch buffering, check and commit
// ----------------------------------------------------------------------------
`include "atomic_site_update_vacancy_set_defines.svh"

module asvs_ctrl
    import asvs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_action,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_START  = 4'd2;
    localparam logic [3:0] ST_CHK_RD = 4'd3;
    localparam logic [3:0] ST_CHK_CMP= 4'd4;
    localparam logic [3:0] ST_CNT    = 4'd5;
    localparam logic [3:0] ST_SPW    = 4'd6;
    localparam logic [3:0] ST_RM_RD  = 4'd7;
    localparam logic [3:0] ST_RM_WR  = 4'd8;
    localparam logic [3:0] ST_RM_MV  = 4'd9;
    localparam logic [3:0] ST_AD_RD  = 4'd10;
    localparam logic [3:0] ST_AD_WR  = 4'd11;
    localparam logic [3:0] ST_RESULT = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.push = accept;
                if (accept && i_last_action) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start   = 1'b1;
                o_cmd.idx_clr = 1'b1;
                if (i_sts.bad) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = ST_RESULT;
                end else begin
                    n_state = ST_CHK_RD;
                end
            end
            ST_CHK_RD: begin
                o_cmd.chk_rd = 1'b1;
                n_state      = ST_CHK_CMP;
            end
            ST_CHK_CMP: begin
                o_cmd.chk_cmp = 1'b1;
                if (i_sts.mismatch) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = ST_RESULT;
                end else if (i_sts.idx_last) begin
                    n_state = ST_CNT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_CHK_RD;
                end
            end
            ST_CNT: begin
                if (!i_sts.count_ok) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = ST_RESULT;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_SPW;
                end
            end
            ST_SPW: begin
                o_cmd.spw = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_RM_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_RM_RD: begin
                if (i_sts.rm_q) begin
                    o_cmd.rm_rd = 1'b1;
                    n_state     = ST_RM_WR;
                end else if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_AD_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_RM_WR: begin
                o_cmd.rm_wr = 1'b1;
                if (i_sts.rm_move) begin
                    n_state = ST_RM_MV;
                end else if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_AD_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_RM_RD;
                end
            end
            ST_RM_MV: begin
                o_cmd.rm_mv = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_AD_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_RM_RD;
                end
            end
            ST_AD_RD: begin
                if (i_sts.ad_q) begin
                    o_cmd.ad_rd = 1'b1;
                    n_state     = ST_AD_WR;
                end else if (i_sts.idx_last) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_AD_WR: begin
                o_cmd.ad_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_AD_RD;
                end
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.end_batch = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    `ASVS_ASSERT_NOW(a_load_free, o_cmd.load_out, i_sts.out_free, "result loaded over a waiting one")
    `ASVS_ASSERT_NOW(a_clear_block, r_state == ST_CLEAR, !o_in_ready, "item taken during clearing")
    `ASVS_ASSERT_NEXT(a_last_start, accept && i_last_action, r_state == ST_START, "batch end missed")

endmodule

// ===== rtl/asvs_dp.sv =====
// ----------------------------------------------------------------------------
// asvs_dp
// species store, vacancy list, batch buffer and result register
// ----------------------------------------------------------------------------
`include "atomic_site_update_vacancy_set_defines.svh"

module asvs_dp
    import asvs_pkg::*;
#(
    parameter int NUM_SITES     = 4096,
    parameter int MAX_VACANCIES = 256,
    parameter int MAX_ACTIONS   = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [SITE_W-1:0]     i_site,
    input  logic [CODE_W-1:0]     i_before_req,
    input  logic [CODE_W-1:0]     i_after,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_status,
    output logic [COUNT_W-1:0]    o_vacancy_count
);

    localparam int SAW = $clog2(NUM_SITES);
    localparam int PW  = (MAX_VACANCIES > 1) ? $clog2(MAX_VACANCIES) : 1;
    localparam int TW  = $clog2(MAX_VACANCIES + 1);
    localparam int IW  = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int NW  = $clog2(MAX_ACTIONS + 1);

    logic [CODE_W-1:0]  r_vc;
    logic [COUNT_W-1:0] r_limit;

    logic [CODE_W-1:0] r_species [NUM_SITES];
    logic [PW:0]       r_pos     [NUM_SITES];
    logic [SITE_W-1:0] r_vlist   [MAX_VACANCIES];

    logic [SITE_W-1:0] r_bs [MAX_ACTIONS];
    logic [CODE_W-1:0] r_bb [MAX_ACTIONS];
    logic [CODE_W-1:0] r_ba [MAX_ACTIONS];

    logic [NW-1:0]      r_n;
    logic               r_bad;
    logic [IW-1:0]      r_idx;
    logic [NW-1:0]      r_add;
    logic [NW-1:0]      r_sub;
    logic               r_fail;
    logic [TW-1:0]      r_total;
    logic [SAW-1:0]     r_clr_addr;
    logic [CODE_W-1:0]  r_sp_rd;
    logic [PW:0]        r_pos_rd;
    logic [SITE_W-1:0]  r_moved;
    logic               r_out_valid;
    logic               r_status;
    logic [COUNT_W-1:0] r_count;

    logic [SITE_W-1:0] cur_site;
    logic [CODE_W-1:0] cur_before;
    logic [CODE_W-1:0] cur_after;
    logic [SAW-1:0]    cur_addr;
    logic              dup;
    logic              in_range;
    logic [TW-1:0]     last;
    logic [PW-1:0]     k;
    logic              do_rm;
    logic              rm_move;
    logic              do_ad;
    logic              moved_ok;
    logic [31:0]       lim;
    logic [31:0]       sum;

    logic              sp_we;
    logic [SAW-1:0]    sp_wa;
    logic [CODE_W-1:0] sp_wd;
    logic              pos_we;
    logic [SAW-1:0]    pos_wa;
    logic [PW:0]       pos_wd;
    logic              vl_we;
    logic [PW-1:0]     vl_wa;
    logic [SITE_W-1:0] vl_wd;

    assign cur_site   = r_bs[r_idx];
    assign cur_before = r_bb[r_idx];
    assign cur_after  = r_ba[r_idx];
    assign cur_addr   = SAW'(cur_site);
    assign in_range   = ({20'd0, i_site} < 32'(NUM_SITES));
    assign last       = r_total - TW'(1);
    assign k          = r_pos_rd[PW-1:0];
    assign do_rm      = r_pos_rd[PW] && (r_total != '0) && (TW'(k) <= last);
    assign rm_move    = do_rm && (TW'(k) != last);
    assign do_ad      = !r_pos_rd[PW] && (r_total < TW'(MAX_VACANCIES));
    assign moved_ok   = ({20'd0, r_moved} < 32'(NUM_SITES));
    assign lim        = (32'(r_limit) < 32'(MAX_VACANCIES)) ? 32'(r_limit)
                                                             : 32'(MAX_VACANCIES);
    assign sum        = 32'(r_total) + 32'(r_add);

    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < MAX_ACTIONS; j++) begin
            if ((NW'(j) < r_n) && (r_bs[j] == i_site)) begin
                dup = 1'b1;
            end
        end
    end

    assign o_sts.clr_done = (r_clr_addr == SAW'(NUM_SITES - 1));
    assign o_sts.bad      = r_bad;
    assign o_sts.mismatch = (r_sp_rd != cur_before);
    assign o_sts.count_ok = (sum >= 32'(r_sub)) && ((sum - 32'(r_sub)) <= lim);
    assign o_sts.idx_last = ((NW'(r_idx) + NW'(1)) == r_n);
    assign o_sts.rm_q     = (cur_before == r_vc) && (cur_after != r_vc);
    assign o_sts.ad_q     = (cur_before != r_vc) && (cur_after == r_vc);
    assign o_sts.rm_move  = rm_move;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // memory write ports
    always_comb begin
        sp_we  = i_cmd.clr_step || i_cmd.spw;
        sp_wa  = i_cmd.clr_step ? r_clr_addr : cur_addr;
        sp_wd  = i_cmd.clr_step ? '0 : cur_after;
        pos_we = i_cmd.clr_step || (i_cmd.rm_wr && do_rm) || (i_cmd.rm_mv && moved_ok)
                 || (i_cmd.ad_wr && do_ad);
        pos_wa = cur_addr;
        pos_wd = {1'b1, PW'(r_total)};
        if (i_cmd.clr_step) begin
            pos_wa = r_clr_addr;
            pos_wd = '0;
        end else if (i_cmd.rm_wr) begin
            pos_wd = {1'b0, k};
        end else if (i_cmd.rm_mv) begin
            pos_wa = SAW'(r_moved);
            pos_wd = {1'b1, k};
        end
        vl_we = (i_cmd.rm_wr && rm_move) || (i_cmd.ad_wr && do_ad);
        vl_wa = i_cmd.rm_wr ? k : PW'(r_total);
        vl_wd = i_cmd.rm_wr ? r_moved : cur_site;
    end

    always_ff @(posedge i_clk) begin
        if (sp_we) begin
            r_species[sp_wa] <= sp_wd;
        end
        if (i_cmd.chk_rd) begin
            r_sp_rd <= r_species[cur_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos[pos_wa] <= pos_wd;
        end
        if (i_cmd.rm_rd || i_cmd.ad_rd) begin
            r_pos_rd <= r_pos[cur_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vl_we) begin
            r_vlist[vl_wa] <= vl_wd;
        end
        if (i_cmd.rm_rd) begin
            r_moved <= r_vlist[PW'(last)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_n < NW'(MAX_ACTIONS))) begin
            r_bs[r_n[IW-1:0]] <= i_site;
            r_bb[r_n[IW-1:0]] <= i_before_req;
            r_ba[r_n[IW-1:0]] <= i_after;
        end
        if (i_cmd.load_out) begin
            r_status <= r_fail;
            r_count  <= COUNT_W'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= VACANT_CODE_RST;
            r_limit     <= VACANCY_LIMIT_RST;
            r_n         <= '0;
            r_bad       <= 1'b0;
            r_idx       <= '0;
            r_add       <= '0;
            r_sub       <= '0;
            r_fail      <= 1'b0;
            r_total     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_VACANT_CODE:   r_vc    <= i_cfg_data[CODE_W-1:0];
                    REG_VACANCY_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + SAW'(1);
            end
            if (i_cmd.push) begin
                if (r_n < NW'(MAX_ACTIONS)) begin
                    r_n <= r_n + NW'(1);
                    if (!in_range || dup) begin
                        r_bad <= 1'b1;
                    end
                end else begin
                    r_bad <= 1'b1;
                end
            end
            if (i_cmd.end_batch) begin
                r_n   <= '0;
                r_bad <= 1'b0;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.start) begin
                r_add  <= '0;
                r_sub  <= '0;
                r_fail <= 1'b0;
            end
            if (i_cmd.chk_cmp) begin
                r_add <= r_add + NW'(cur_after == r_vc);
                r_sub <= r_sub + NW'(cur_before == r_vc);
            end
            if (i_cmd.set_fail) begin
                r_fail <= 1'b1;
            end
            if (i_cmd.rm_wr && do_rm) begin
                r_total <= last;
            end else if (i_cmd.ad_wr && do_ad) begin
                r_total <= r_total + TW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_vacancy_count = r_count;

    `ASVS_ASSERT_NOW(a_total_max, 1'b1, r_total <= TW'(MAX_VACANCIES), "vacancy total overflow")
    `ASVS_ASSERT_NOW(a_pend_max, 1'b1, r_n <= NW'(MAX_ACTIONS), "batch buffer overflow")
    `ASVS_ASSERT_NEXT(a_add_grow, i_cmd.ad_wr && do_ad, r_total == $past(r_total) + TW'(1), "append lost")

endmodule

// ===== rtl/atomic_site_update_vacancy_set.sv =====
// ----------------------------------------------------------------------------
// atomic_site_update_vacancy_set
// lattice species store with a vacancy list, updated in checked batches
// ----------------------------------------------------------------------------
// site actions arrive one item at a time on the input channel; items with
// i_last_action low are buffered, with no result
// the last item of a batch starts check and commit and gives one result item
// check reads and compares the stored species of each buffered action, then
// tests the vacancy count; commit writes the species of each action, then
// does the list updates, one access a cycle per memory, and then the result
// is loaded; a rejected batch skips commit; the input is held from the last
// item of a batch until its result is loaded
// after reset the site memory is cleared, one site a cycle,
// and no item is taken until that is done; configuration writes are always
// taken and must be made while no batch is in progress
// the result sits in an output register; while the receiver stalls, further
// items are taken until a batch end must deliver its result, which then waits
// ----------------------------------------------------------------------------
module atomic_site_update_vacancy_set
    import asvs_pkg::*;
#(
    parameter int NUM_SITES     = 4096,
    parameter int MAX_VACANCIES = 256,
    parameter int MAX_ACTIONS   = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SITE_W-1:0]     i_site,
    input  logic [CODE_W-1:0]     i_before_req,
    input  logic [CODE_W-1:0]     i_after,
    input  logic                  i_last_action,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_status,
    output logic [COUNT_W-1:0]    o_vacancy_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    asvs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_action (i_last_action),
        .o_in_ready    (o_in_ready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    asvs_dp #(
        .NUM_SITES     (NUM_SITES),
        .MAX_VACANCIES (MAX_VACANCIES),
        .MAX_ACTIONS   (MAX_ACTIONS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_site          (i_site),
        .i_before_req    (i_before_req),
        .i_after         (i_after),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_vacancy_count (o_vacancy_count)
    );

endmodule

// ===== verif/asvs_checker.sv =====
// ----------------------------------------------------------------------------
// asvs_checker
// watches the item, result and register channels of the site update block,
// predicts each batch outcome and compares it with the result item
// ----------------------------------------------------------------------------
module asvs_checker
    import asvs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SITE_W-1:0]     i_site,
    input  logic [CODE_W-1:0]     i_before_req,
    input  logic [CODE_W-1:0]     i_after,
    input  logic                  i_last_action,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_status,
    input  logic [COUNT_W-1:0]    i_vacancy_count,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SITES = 4096;
    localparam int LIST_DEPTH = 256;
    localparam int BATCH_DEPTH = 4;

    typedef struct packed {
        logic [SITE_W-1:0] site;
        logic [CODE_W-1:0] before_req;
        logic [CODE_W-1:0] after;
    } t_action;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    logic [CODE_W-1:0]  vac_code;
    logic [COUNT_W-1:0] vac_limit;
    logic [CODE_W-1:0]  species [N_SITES];
    logic [SITE_W-1:0]  site_list [LIST_DEPTH];
    int                 list_pos [N_SITES];
    bit                 listed [N_SITES];
    int                 vac_total;
    t_action            batch_q [$];
    bit                 overflow;
    t_outcome           outcome_q [$];

    initial begin
        vac_code = VACANT_CODE_RST;
        vac_limit = VACANCY_LIMIT_RST;
        vac_total = 0;
        overflow = 0;
        for (int i = 0; i < N_SITES; i++) begin
            species[i] = '0;
            listed[i] = 0;
            list_pos[i] = 0;
        end
    end

    task automatic report(input string what, input int got, input int want);
        o_errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic bit batch_passes();
        int lim;
        int cnt;
        lim = (vac_limit > LIST_DEPTH) ? LIST_DEPTH : vac_limit;
        cnt = vac_total;
        if (overflow) return 0;
        foreach (batch_q[i])
            if (species[batch_q[i].site] != batch_q[i].before_req) return 0;
        foreach (batch_q[i])
            for (int j = i + 1; j < batch_q.size(); j++)
                if (batch_q[i].site == batch_q[j].site) return 0;
        foreach (batch_q[i]) begin
            if (batch_q[i].after == vac_code) cnt++;
            if (batch_q[i].before_req == vac_code) cnt--;
        end
        return (cnt >= 0 && cnt <= lim);
    endfunction

    task automatic apply_batch();
        int s;
        int k;
        int tail;
        foreach (batch_q[i]) species[batch_q[i].site] = batch_q[i].after;
        // vacated sites leave the list first, swapping the tail entry in
        foreach (batch_q[i]) begin
            s = batch_q[i].site;
            if (batch_q[i].before_req == vac_code && batch_q[i].after != vac_code &&
                listed[s] && vac_total != 0) begin
                k = list_pos[s];
                tail = vac_total - 1;
                if (k <= tail) begin
                    if (k != tail) begin
                        site_list[k] = site_list[tail];
                        list_pos[site_list[tail]] = k;
                    end
                    listed[s] = 0;
                    vac_total = tail;
                end
            end
        end
        foreach (batch_q[i]) begin
            s = batch_q[i].site;
            if (batch_q[i].before_req != vac_code && batch_q[i].after == vac_code &&
                !listed[s] && vac_total < LIST_DEPTH) begin
                site_list[vac_total] = s;
                list_pos[s] = vac_total;
                listed[s] = 1;
                vac_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        bit       ok;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_VACANT_CODE) vac_code = i_cfg_data[CODE_W-1:0];
                else if (i_cfg_index == REG_VACANCY_LIMIT) vac_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (batch_q.size() < BATCH_DEPTH)
                    batch_q.push_back('{i_site, i_before_req, i_after});
                else
                    overflow = 1;
                if (i_last_action) begin
                    ok = batch_passes();
                    if (ok) apply_batch();
                    batch_q.delete();
                    overflow = 0;
                    want.status = !ok;
                    want.count = vac_total[COUNT_W-1:0];
                    outcome_q.push_back(want);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    report("unexpected result item", i_status, 0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_status !== want.status) report("status", i_status, want.status);
                    if (i_vacancy_count !== want.count)
                        report("vacancy_count", i_vacancy_count, want.count);
                end
            end
        end
        o_waiting = outcome_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random batches of site actions through the site update
// block under several register settings, with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_top;
    import asvs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SITE_W-1:0] site;
        logic [CODE_W-1:0] before_req;
        logic [CODE_W-1:0] after;
    } t_action;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [SITE_W-1:0]     i_site;
    logic [CODE_W-1:0]     i_before_req;
    logic [CODE_W-1:0]     i_after;
    logic                  i_last_action;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_status;
    logic [COUNT_W-1:0]    o_vacancy_count;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    chk_errors;
    int                    chk_waiting;

    logic [CODE_W-1:0] shadow [4096];
    logic [CODE_W-1:0] cur_vac;
    int  results_seen;
    bit  last_status;
    bit  quiet;
    int  n_items;
    int  n_applied;
    int  n_rejected;
    int  n_cfg;

    atomic_site_update_vacancy_set i_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_site, .i_before_req, .i_after,
        .i_last_action, .o_out_valid, .i_out_ready, .o_status, .o_vacancy_count,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    asvs_checker i_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_site, .i_before_req,
        .i_after, .i_last_action, .i_out_valid(o_out_valid), .i_out_ready,
        .i_status(o_status), .i_vacancy_count(o_vacancy_count), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(chk_errors), .o_waiting(chk_waiting)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            last_status = o_status;
        end
    end

    // receiver stalls
    initial begin
        int k;
        i_out_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            k = quiet ? 0 : $urandom_range(0, 4);
            if (k != 0) begin
                i_out_ready <= 0;
                repeat (k) @(posedge i_clk);
            end
            i_out_ready <= 1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_cfg++;
        if (idx == REG_VACANT_CODE) cur_vac = data[CODE_W-1:0];
    endtask

    task automatic send_item(input t_action a, input bit last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_site <= a.site;
        i_before_req <= a.before_req;
        i_after <= a.after;
        i_last_action <= last;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
    endtask

    task automatic run_batch(input t_action acts [$]);
        int target;
        target = results_seen + 1;
        foreach (acts[i]) send_item(acts[i], i == acts.size() - 1);
        i_in_valid <= 0;
        wait (results_seen == target);
        if (last_status == 0) begin
            n_applied++;
            foreach (acts[i]) shadow[acts[i].site] = acts[i].after;
        end else begin
            n_rejected++;
        end
    endtask

    task automatic random_batch();
        t_action acts [$];
        t_action a;
        int n;
        int r;
        n = ($urandom_range(0, 99) < 8) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8 && i > 0) a.site = acts[$urandom_range(0, i - 1)].site;
            else if (r < 18) a.site = SITE_W'($urandom_range(0, 4095));
            else a.site = SITE_W'($urandom_range(0, 31));
            a.before_req = ($urandom_range(0, 99) < 6) ? CODE_W'($urandom_range(0, 255))
                                                       : shadow[a.site];
            r = $urandom_range(0, 99);
            if (r < 45) a.after = cur_vac;
            else if (r < 55) a.after = 0;
            else a.after = CODE_W'($urandom_range(0, 255));
            acts.push_back(a);
        end
        run_batch(acts);
    endtask

    initial begin
        logic [CODE_W-1:0]  codes [6] = '{8'd255, 8'd7, 8'd7, 8'd1, 8'd255, 8'd128};
        logic [COUNT_W-1:0] lims [6]  = '{9'd256, 9'd4, 9'd0, 9'd511, 9'd3, 9'd40};
        i_rst_n = 0;
        i_in_valid = 0;
        i_site = 0;
        i_before_req = 0;
        i_after = 0;
        i_last_action = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        results_seen = 0;
        quiet = 0;
        cur_vac = VACANT_CODE_RST;
        foreach (shadow[i]) shadow[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed batches under reset register values
        run_batch('{'{12'd0, 8'd0, 8'd255}});
        run_batch('{'{12'd4095, 8'd255, 8'd0}});
        run_batch('{'{12'd4095, 8'd0, 8'd255}, '{12'd1, 8'd0, 8'd255},
                    '{12'd2, 8'd0, 8'd170}, '{12'd3, 8'd0, 8'd85}});
        run_batch('{'{12'd5, 8'd0, 8'd255}, '{12'd6, 8'd0, 8'd255}, '{12'd7, 8'd0, 8'd1},
                    '{12'd8, 8'd0, 8'd1}, '{12'd9, 8'd0, 8'd1}});
        run_batch('{'{12'd10, 8'd0, 8'd255}, '{12'd10, 8'd0, 8'd255}});
        run_batch('{'{12'd0, 8'd255, 8'd7}, '{12'd2, 8'd170, 8'd255}});
        run_batch('{'{12'd1, 8'd255, 8'd0}});

        for (int p = 0; p < 6; p++) begin
            repeat (40) @(posedge i_clk);
            write_reg(REG_VACANT_CODE, {1'b0, codes[p]});
            write_reg(REG_VACANCY_LIMIT, lims[p]);
            if (p == 3) write_reg(8'hff, 9'h1ff);
            i_cfg_valid <= 0;
            quiet = (p == 2);
            while (n_items < 30 + (p + 1) * 100) random_batch();
        end

        wait (chk_waiting == 0);
        repeat (60) @(posedge i_clk);
        $display("sent %0d items in %0d applied and %0d rejected batches, %0d register writes",
                 n_items, n_applied, n_rejected, n_cfg);
        if (chk_errors == 0 && chk_waiting == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
